// ===== hdl/pdir_pkg.sv =====
// ----------------------------------------------------------------------------
// pdir_pkg
// Types and constants for the particle decay, integrate and respawn core.
// ----------------------------------------------------------------------------
package pdir_pkg;

  // Register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_DECAY     = 1'b1
  } cfg_reg_e;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] THRESHOLD_RST = 16'd655;
  localparam logic [15:0] DECAY_RST     = 16'd58982;

  // Q0.16 constants
  localparam logic [31:0] Q16_0P7  = 32'd45875;
  localparam logic [15:0] Q16_0P3  = 16'd19661;
  localparam logic [15:0] Q16_0P15 = 16'd9830;
  localparam logic [31:0] Q16_0P01 = 32'd655;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;

  // Result queue behind the pipeline
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One particle entry; positions and velocities are signed Q16.16
  typedef struct packed {
    logic [31:0] accel_y;
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [15:0] bright;
  } particle_t;

  localparam int PARTICLE_W = $bits(particle_t);

  // One result word, last field lowest
  typedef struct packed {
    logic        respawned;
    logic [17:0] gray_level;
    logic [31:0] new_pos_y;
    logic [31:0] new_pos_x;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hdl/pdir_ram.sv =====
// ----------------------------------------------------------------------------
// pdir_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pdir_ram #(
  parameter int WIDTH = 176,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pdir_fifo.sv =====
// ----------------------------------------------------------------------------
// pdir_fifo
// Small result queue between the update pipeline and the output stream.
// ----------------------------------------------------------------------------
module pdir_fifo #(
  parameter int WIDTH = 83,
  parameter int DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               push_data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output logic [WIDTH-1:0]               data_o,
  output logic [$clog2(DEPTH + 1)-1:0]   count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// ===== hdl/particle_decay_integrate_respawn_core.sv =====
// ----------------------------------------------------------------------------
// particle_decay_integrate_respawn_core
// Per-particle brightness decay, Euler step and respawn over a particle RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per particle update (index plus four random
//   fractions). Master stream: one word per update (new position, grey
//   level) with the respawn flag on tuser. Registers are written through
//   cfg_we_i / cfg_addr_i / cfg_wdata_i while the block is idle.
//   Throughput: one word per cycle while s_axis_tready is high. The
//   particle RAM is read and written once per cycle; a particle updated
//   on consecutive words is forwarded from the later stages, so the
//   stage 2 update (brightness multiply, saturating adds) plus its bypass
//   mux is the only loop and it closes in one stage. From input handshake
//   to the earliest output handshake a word passes index reduce and RAM
//   read, respawn products, update and queue. Reset: the particle RAM is
//   cleared by a sweep over all PARTICLE_COUNT entries, one entry per
//   cycle; s_axis_tready stays low until it ends. Stall: finished words
//   wait in an 8-entry queue. s_axis_tready drops only once queued plus
//   in-flight words fill it, so nothing is lost and input flows meanwhile.
// ----------------------------------------------------------------------------
module particle_decay_integrate_respawn_core
  import pdir_pkg::*;
#(
  parameter int PARTICLE_COUNT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // particle_index, rand_brightness, rand_vel_x, rand_vel_y, rand_accel_y
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_pos_x, new_pos_y, gray_level
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // respawned
  output logic [0:0]            m_axis_tuser
);

  localparam int IDX_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [15:0] thr_q;
  logic [15:0] decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      decay_q <= DECAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_THRESHOLD: thr_q   <= cfg_wdata_i;
        CFG_DECAY:     decay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing sweep after reset
  // --------------------------------------------------------------------------
  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == IDX_W'(PARTICLE_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input: unpack and reduce index modulo PARTICLE_COUNT
  // --------------------------------------------------------------------------
  logic [7:0]        in_idx;
  logic [14:0]       in_rb, in_rx, in_ry, in_ra;
  logic [7:0]        idx_rem;
  logic [IDX_W+7:0]  idx_ext;
  logic [IDX_W-1:0]  acc_idx;
  logic              accept;
  logic [1:0]        inflight;
  logic [FIFO_CNT_W-1:0] fifo_cnt;

  assign in_idx = s_axis_tdata[7:0];
  assign in_rb  = s_axis_tdata[22:8];
  assign in_rx  = s_axis_tdata[37:23];
  assign in_ry  = s_axis_tdata[52:38];
  assign in_ra  = s_axis_tdata[67:53];

  // restoring reduction, one shifted modulus per step
  always_comb begin
    idx_rem = in_idx;
    for (int k = 7; k >= 0; k--) begin
      if ({12'd0, idx_rem} >= (20'(PARTICLE_COUNT) << k)) begin
        idx_rem = idx_rem - 8'(20'(PARTICLE_COUNT) << k);
      end
    end
  end

  assign idx_ext = {{IDX_W{1'b0}}, idx_rem};
  assign acc_idx = idx_ext[IDX_W-1:0];

  assign s_axis_tready = !clr_busy_q &&
                         (({1'b0, fifo_cnt} + (FIFO_CNT_W + 1)'(inflight))
                          < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign accept = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Particle RAM
  // --------------------------------------------------------------------------
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  particle_t        ram_wdata;
  particle_t        ram_rdata;

  // --------------------------------------------------------------------------
  // Stage 1: RAM data arrives; respawn products
  // --------------------------------------------------------------------------
  logic             s1_v_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [14:0]      s1_rb_q, s1_rx_q, s1_ry_q, s1_ra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= acc_idx;
    s1_rb_q  <= in_rb;
    s1_rx_q  <= in_rx;
    s1_ry_q  <= in_ry;
    s1_ra_q  <= in_ra;
  end

  logic signed [16:0] vx_diff;
  logic signed [33:0] vx_prod;
  logic [31:0]        vy_prod;
  logic [31:0]        ay_prod;
  logic [32:0]        ay_sum;
  logic [31:0]        sp_vx, sp_vy, sp_ay;

  assign vx_diff = $signed({1'b0, s1_rx_q, 1'b0}) - 17'sd32768;
  assign vx_prod = 34'(vx_diff) * 34'sd45875;
  assign sp_vx   = {{14{vx_prod[33]}}, vx_prod[33:16]};

  assign vy_prod = {16'd0, s1_ry_q, 1'b0} * {16'd0, Q16_0P3};
  assign sp_vy   = {16'd0, vy_prod[31:16]} + Q16_0P7;

  // floor of a negated product is minus its ceiling
  assign ay_prod = {16'd0, s1_ra_q, 1'b0} * {16'd0, Q16_0P15};
  assign ay_sum  = {1'b0, ay_prod} + 33'd65535;
  assign sp_ay   = 32'd0 - {15'd0, ay_sum[32:16]} - Q16_0P01;

  // --------------------------------------------------------------------------
  // Stage 2: bypass, decide, decay and integrate
  // --------------------------------------------------------------------------
  logic             s2_v_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic [14:0]      s2_rb_q;
  logic [31:0]      s2_vx_q, s2_vy_q, s2_ay_q;
  particle_t        s2_st_q, s2_st_d;

  logic             s3_v_q;
  logic [IDX_W-1:0] s3_idx_q;
  logic             s3_resp_q, s3_resp_d;
  particle_t        s3_st_q, s3_st_d;

  logic             w_v_q;
  logic [IDX_W-1:0] w_idx_q;
  particle_t        w_st_q;

  // take the newest copy of the entry: stage 3, then the last write, then RAM
  always_comb begin
    if (s3_v_q && (s3_idx_q == s1_idx_q)) begin
      s2_st_d = s3_st_q;
    end else if (w_v_q && (w_idx_q == s1_idx_q)) begin
      s2_st_d = w_st_q;
    end else begin
      s2_st_d = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_idx_q <= s1_idx_q;
    s2_rb_q  <= s1_rb_q;
    s2_vx_q  <= sp_vx;
    s2_vy_q  <= sp_vy;
    s2_ay_q  <= sp_ay;
    s2_st_q  <= s2_st_d;
  end

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  particle_t   cur;
  logic [31:0] dec_prod;

  always_comb begin
    // the item just ahead may have touched the same particle
    if (s3_v_q && (s3_idx_q == s2_idx_q)) begin
      cur = s3_st_q;
    end else begin
      cur = s2_st_q;
    end
    dec_prod = {16'd0, cur.bright} * {16'd0, decay_q};
    if (cur.bright > thr_q) begin
      s3_resp_d       = 1'b0;
      s3_st_d.bright  = dec_prod[31:16];
      s3_st_d.pos_x   = sat_add(cur.pos_x, cur.vel_x);
      s3_st_d.pos_y   = sat_add(cur.pos_y, cur.vel_y);
      s3_st_d.vel_x   = cur.vel_x;
      s3_st_d.vel_y   = sat_add(cur.vel_y, cur.accel_y);
      s3_st_d.accel_y = cur.accel_y;
    end else begin
      s3_resp_d       = 1'b1;
      s3_st_d.bright  = {s2_rb_q, 1'b0};
      s3_st_d.pos_x   = '0;
      s3_st_d.pos_y   = '0;
      s3_st_d.vel_x   = s2_vx_q;
      s3_st_d.vel_y   = s2_vy_q;
      s3_st_d.accel_y = s2_ay_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: write back and queue the result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      w_v_q  <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
      if (s3_v_q) begin
        w_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s3_idx_q  <= s2_idx_q;
    s3_resp_q <= s3_resp_d;
    s3_st_q   <= s3_st_d;
    if (s3_v_q) begin
      w_idx_q <= s3_idx_q;
      w_st_q  <= s3_st_q;
    end
  end

  assign ram_we    = clr_busy_q || s3_v_q;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : s3_idx_q;
  assign ram_wdata = clr_busy_q ? '0 : s3_st_q;

  pdir_ram #(
    .WIDTH (PARTICLE_W),
    .DEPTH (PARTICLE_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (acc_idx),
    .rdata_o (ram_rdata)
  );

  result_t res_push;
  result_t res_head;

  assign res_push.new_pos_x  = s3_st_q.pos_x;
  assign res_push.new_pos_y  = s3_st_q.pos_y;
  assign res_push.gray_level = {2'b00, s3_st_q.bright} + {1'b0, s3_st_q.bright, 1'b0};
  assign res_push.respawned  = s3_resp_q;

  assign inflight = 2'({1'b0, s1_v_q} + {1'b0, s2_v_q} + {1'b0, s3_v_q});

  pdir_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_v_q),
    .push_data_i (res_push),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (res_head),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tdata = {6'd0, res_head.gray_level, res_head.new_pos_y, res_head.new_pos_x};
  assign m_axis_tuser = res_head.respawned;

`ifndef SYNTH
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(s1_v_q || s2_v_q || s3_v_q))
    else $error("pipeline holds a word during the clearing sweep");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fifo_cnt} + (FIFO_CNT_W + 1)'(inflight)) <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
    else $error("queued plus in-flight words exceed the result queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |=> (fifo_cnt != '0))
    else $error("finished word did not reach the result queue");

  a_respawn_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && s3_resp_q) |-> ((s3_st_q.pos_x == '0) && (s3_st_q.pos_y == '0)))
    else $error("respawned particle not at the origin");
`endif

endmodule
